[rtl/irc_tok_pkg.sv]
// ----------------------------------------------------------------------------
// irc_tok_pkg
// Shared types and character codes for the IRC line tokenizer.
// ----------------------------------------------------------------------------
package irc_tok_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_OPEN    = 3'd1,
    PH_PREFIX  = 3'd2,
    PH_COMMAND = 3'd3,
    PH_SEP     = 3'd4,
    PH_MIDDLE  = 3'd5,
    PH_TRAIL   = 3'd6,
    PH_CR      = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    K_PREFIX  = 3'd0,
    K_COMMAND = 3'd1,
    K_MIDDLE  = 3'd2,
    K_TRAIL   = 3'd3,
    K_DELIM   = 3'd4
  } kind_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] param_count;
    logic       line_nonempty;
  } parse_state_t;

  typedef struct packed {
    kind_t      field_kind;
    logic [3:0] param_index;
    logic       token_start;
    logic       message_end;
    logic       malformed;
  } byte_tag_t;

endpackage

[rtl/irc_tok_step.sv]
// ----------------------------------------------------------------------------
// irc_tok_step
// Per-byte parse step: tags one octet and computes the next parser state.
// ----------------------------------------------------------------------------
module irc_tok_step import irc_tok_pkg::*; #(
  parameter int MAX_PARAMS = 15
) (
  input  logic [7:0]   data_byte,
  input  parse_state_t state,
  output parse_state_t state_nxt,
  output byte_tag_t    tag
);

  localparam logic [3:0] MaxCount = 4'(MAX_PARAMS);

  logic         cr_lf;
  logic         cr_stray;
  parse_state_t eff;
  logic         can_open;
  logic [3:0]   opened_cnt;
  logic [3:0]   idx_cur;
  logic [3:0]   idx_open;

  // A CR followed by anything but LF drops the line; the byte then starts a new one.
  assign cr_lf    = (state.phase == PH_CR) && (data_byte == CH_LF);
  assign cr_stray = (state.phase == PH_CR) && (data_byte != CH_LF);

  always_comb begin
    eff = state;
    if (cr_stray) begin
      eff.phase         = PH_START;
      eff.param_count   = 4'd0;
      eff.line_nonempty = 1'b0;
    end
  end

  assign can_open   = eff.param_count < MaxCount;
  assign opened_cnt = can_open ? eff.param_count + 4'd1 : MaxCount;
  assign idx_cur    = (eff.param_count == 4'd0) ? 4'd0 : eff.param_count - 4'd1;
  assign idx_open   = opened_cnt - 4'd1;

  // next state
  always_comb begin
    state_nxt = eff;
    if (cr_lf) begin
      state_nxt.phase         = PH_START;
      state_nxt.param_count   = 4'd0;
      state_nxt.line_nonempty = 1'b0;
    end else if (data_byte == CH_NUL) begin
      state_nxt = eff;
    end else if (data_byte == CH_CR) begin
      state_nxt.phase = PH_CR;
    end else if (data_byte == CH_LF) begin
      state_nxt.phase         = PH_START;
      state_nxt.param_count   = 4'd0;
      state_nxt.line_nonempty = 1'b0;
    end else begin
      state_nxt.line_nonempty = 1'b1;
      unique case (eff.phase)
        PH_START: begin
          if (!eff.line_nonempty && data_byte == CH_COLON) begin
            state_nxt.phase = PH_OPEN;
          end else if (data_byte != CH_SPACE) begin
            state_nxt.phase = PH_COMMAND;
          end
        end
        PH_OPEN: begin
          if (eff.param_count == 4'd0) begin
            state_nxt.phase = (data_byte == CH_SPACE) ? PH_START : PH_PREFIX;
          end else begin
            state_nxt.phase = PH_TRAIL;
          end
        end
        PH_PREFIX: begin
          if (data_byte == CH_SPACE) state_nxt.phase = PH_START;
        end
        PH_COMMAND: begin
          if (data_byte == CH_SPACE) state_nxt.phase = PH_SEP;
        end
        PH_SEP: begin
          if (data_byte == CH_COLON) begin
            state_nxt.param_count = opened_cnt;
            state_nxt.phase       = PH_OPEN;
          end else if (data_byte != CH_SPACE) begin
            state_nxt.param_count = opened_cnt;
            state_nxt.phase       = PH_MIDDLE;
          end
        end
        PH_MIDDLE: begin
          if (data_byte == CH_SPACE) state_nxt.phase = PH_SEP;
        end
        default: begin
          state_nxt.phase = PH_TRAIL;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    tag.field_kind  = K_DELIM;
    tag.param_index = 4'd0;
    tag.token_start = 1'b0;
    tag.message_end = 1'b0;
    tag.malformed   = cr_stray;
    if (cr_lf) begin
      tag.message_end = state.line_nonempty;
    end else if (data_byte == CH_NUL) begin
      tag.malformed = 1'b1;
    end else if (data_byte == CH_CR) begin
      // line ends before any command byte
      if (eff.line_nonempty && (eff.phase == PH_START || eff.phase == PH_PREFIX ||
          (eff.phase == PH_OPEN && eff.param_count == 4'd0))) begin
        tag.malformed = 1'b1;
      end
    end else if (data_byte == CH_LF) begin
      tag.malformed = 1'b1;
    end else begin
      unique case (eff.phase)
        PH_START: begin
          if (!(!eff.line_nonempty && data_byte == CH_COLON) && data_byte != CH_SPACE) begin
            tag.field_kind  = K_COMMAND;
            tag.token_start = 1'b1;
          end
        end
        PH_OPEN: begin
          if (eff.param_count == 4'd0) begin
            if (data_byte != CH_SPACE) begin
              tag.field_kind  = K_PREFIX;
              tag.token_start = 1'b1;
            end
          end else begin
            tag.field_kind  = K_TRAIL;
            tag.param_index = idx_cur;
            tag.token_start = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (data_byte != CH_SPACE) tag.field_kind = K_PREFIX;
        end
        PH_COMMAND: begin
          if (data_byte != CH_SPACE) tag.field_kind = K_COMMAND;
        end
        PH_SEP: begin
          if (data_byte == CH_COLON) begin
            tag.malformed = tag.malformed | !can_open;
          end else if (data_byte != CH_SPACE) begin
            tag.malformed   = tag.malformed | !can_open;
            tag.field_kind  = K_MIDDLE;
            tag.param_index = idx_open;
            tag.token_start = 1'b1;
          end
        end
        PH_MIDDLE: begin
          if (data_byte != CH_SPACE) begin
            tag.field_kind  = K_MIDDLE;
            tag.param_index = idx_cur;
          end
        end
        default: begin
          tag.field_kind  = K_TRAIL;
          tag.param_index = idx_cur;
        end
      endcase
    end
  end

endmodule

[rtl/irc_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// irc_line_tokenizer
// Streaming RFC 1459 message tokenizer: tags each octet with its field kind,
// parameter index, token start, end of message and fault flag.
// ----------------------------------------------------------------------------
//   channel  | ports                                    | direction
//   ---------+------------------------------------------+----------
//   input    | in_valid, in_ready, in_data_byte         | in
//   result   | out_valid, out_ready, out_echo_byte,     | out
//            | out_field_kind, out_param_index,         |
//            | out_token_start, out_message_end,        |
//            | out_malformed                            |
//
// One octet per clock sustained while out_ready stays high; each byte passes
// the input register, then one parse step into the result register.
// The parser state advances as a byte moves from the input to the result
// register, so a stall on out_ready holds the result register, the state
// and any byte in the input register.
// Synchronous reset returns the parser to line start with both stages empty.
// ----------------------------------------------------------------------------
module irc_line_tokenizer import irc_tok_pkg::*; #(
  parameter int MAX_PARAMS = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_echo_byte,
  output logic [2:0] out_field_kind,
  output logic [3:0] out_param_index,
  output logic       out_token_start,
  output logic       out_message_end,
  output logic       out_malformed
);

  logic         s1_valid_r;
  logic         s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic [7:0]   out_byte_r;
  byte_tag_t    out_tag_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  byte_tag_t    step_tag;
  logic         out_load;
  logic         s1_move;
  logic         in_xfer;

  assign out_load = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || out_load;
  assign in_xfer  = in_valid && in_ready;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  irc_tok_step #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_step (
    .data_byte (s1_byte_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .tag       (step_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: PH_START, param_count: 4'd0, line_nonempty: 1'b0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_move) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) s1_byte_r <= in_data_byte;
    if (s1_move) begin
      out_byte_r <= s1_byte_r;
      out_tag_r  <= step_tag;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_echo_byte   = out_byte_r;
  assign out_field_kind  = out_tag_r.field_kind;
  assign out_param_index = out_tag_r.param_index;
  assign out_token_start = out_tag_r.token_start;
  assign out_message_end = out_tag_r.message_end;
  assign out_malformed   = out_tag_r.malformed;

`ifndef SYNTHESIS
  a_mend_on_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tag_r.message_end |->
      out_byte_r == CH_LF && out_tag_r.field_kind == K_DELIM)
    else $error("message end on a byte other than LF");

  a_start_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tag_r.token_start |-> out_tag_r.field_kind != K_DELIM)
    else $error("token start on a delimiter");

  a_index_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tag_r.param_index != 4'd0 |->
      out_tag_r.field_kind == K_MIDDLE || out_tag_r.field_kind == K_TRAIL)
    else $error("parameter index outside a parameter");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.param_count <= 4'(MAX_PARAMS))
    else $error("parameter count past limit");

  a_cr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && s1_byte_r == CH_CR |=> state_r.phase == PH_CR)
    else $error("CR did not enter CR phase");
`endif

endmodule
